// ----- hw/rtl/hsr_pkg.sv -----
package hsr_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int VALUE_BITS    = 32;
	localparam int WIDE_BITS     = VALUE_BITS + FRACTION_BITS;
	localparam int ROOT_BITS     = (VALUE_BITS + FRACTION_BITS) / 2 + 1;
	localparam int COUNT_BITS    = 6;
	localparam int TOL_BITS      = 16;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;
	localparam int DIV_CNT_BITS  = $clog2(WIDE_BITS);
	localparam int STEP_BITS     = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_STOP_MODE        = 2'd0,
		REG_FIXED_ITERATIONS = 2'd1,
		REG_TOLERANCE        = 2'd2,
		REG_MAX_ITERATIONS   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                  stop_mode;
		logic [COUNT_BITS-1:0] fixed_iterations;
		logic [TOL_BITS-1:0]   tolerance;
		logic [COUNT_BITS-1:0] max_iterations;
	} cfg_t;

	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t ST_IDLE   = 3'd0;
	localparam step_t ST_ZCHK   = 3'd1;
	localparam step_t ST_CHECK  = 3'd2;
	localparam step_t ST_DSTART = 3'd3;
	localparam step_t ST_DWAIT  = 3'd4;
	localparam step_t ST_AVG    = 3'd5;
	localparam step_t ST_UPDATE = 3'd6;
	localparam step_t ST_EMIT   = 3'd7;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV_START,
		OP_AVG,
		OP_UPDATE,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS,
		C_IN_VALID,
		C_Z_ZERO,
		C_CNT_DONE,
		C_DIV_DONE,
		C_TOL_MET,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt_t;
		step_t tgt_f;
	} ctrl_word_t;

	typedef struct packed {
		logic in_valid;
		logic z_zero;
		logic cnt_done;
		logic div_done;
		logic tol_met;
		logic out_free;
	} status_t;

	// microprogram: next = cond ? tgt_t : tgt_f
	function automatic ctrl_word_t ucode(input step_t s);
		ctrl_word_t w;
		unique case (s)
			ST_IDLE:   w = '{OP_LOAD,      C_IN_VALID, ST_ZCHK,   ST_IDLE};
			ST_ZCHK:   w = '{OP_NOP,       C_Z_ZERO,   ST_EMIT,   ST_CHECK};
			ST_CHECK:  w = '{OP_NOP,       C_CNT_DONE, ST_EMIT,   ST_DSTART};
			ST_DSTART: w = '{OP_DIV_START, C_ALWAYS,   ST_DWAIT,  ST_DWAIT};
			ST_DWAIT:  w = '{OP_NOP,       C_DIV_DONE, ST_AVG,    ST_DWAIT};
			ST_AVG:    w = '{OP_AVG,       C_ALWAYS,   ST_UPDATE, ST_UPDATE};
			ST_UPDATE: w = '{OP_UPDATE,    C_TOL_MET,  ST_EMIT,   ST_CHECK};
			ST_EMIT:   w = '{OP_EMIT,      C_OUT_FREE, ST_IDLE,   ST_EMIT};
			default:   w = '{OP_NOP,       C_ALWAYS,   ST_IDLE,   ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ----- hw/rtl/hsr_if.sv -----
interface hsr_in_if import hsr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

interface hsr_out_if import hsr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [ROOT_BITS-1:0]  root;
	logic [COUNT_BITS-1:0] iterations_used;
	logic                  converged;

	modport source (output valid, output root, output iterations_used, output converged,
		input ready);
	modport sink   (input valid, input root, input iterations_used, input converged,
		output ready);
endinterface

interface hsr_cfg_if import hsr_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/hsr_divider.sv -----
module hsr_divider import hsr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WIDE_BITS-1:0] dividend,
	input  logic [WIDE_BITS-1:0] divisor,
	output logic [WIDE_BITS-1:0] quotient,
	output logic                 done
);

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [WIDE_BITS-1:0]    rem_q;
	logic [WIDE_BITS-1:0]    quo_q;
	logic [WIDE_BITS-1:0]    dvs_q;
	logic [WIDE_BITS:0]      shifted;
	logic [WIDE_BITS:0]      trial;
	logic                    fits;

	// restoring radix-2: dividend bits shift out of quo_q as quotient bits shift in
	assign shifted = {rem_q, quo_q[WIDE_BITS-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign fits    = ~trial[WIDE_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == DIV_CNT_BITS'(WIDE_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[WIDE_BITS-1:0] : shifted[WIDE_BITS-1:0];
			quo_q <= {quo_q[WIDE_BITS-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ----- hw/rtl/hsr_sequencer.sv -----
module hsr_sequencer import hsr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  status_t    status,
	output ctrl_word_t ctrl
);

	step_t      step_q;
	ctrl_word_t word;
	logic       taken;

	assign word = ucode(step_q);

	always_comb begin
		unique case (word.cond)
			C_ALWAYS:   taken = 1'b1;
			C_IN_VALID: taken = status.in_valid;
			C_Z_ZERO:   taken = status.z_zero;
			C_CNT_DONE: taken = status.cnt_done;
			C_DIV_DONE: taken = status.div_done;
			C_TOL_MET:  taken = status.tol_met;
			C_OUT_FREE: taken = status.out_free;
			default:    taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= taken ? word.tgt_t : word.tgt_f;
		end
	end

	assign ctrl = word;

endmodule

// ----- hw/rtl/hsr_datapath.sv -----
module hsr_datapath import hsr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  ctrl_word_t           ctrl,
	output status_t              status,
	hsr_in_if.sink               sample,
	hsr_out_if.source            result,
	output logic                 div_start,
	output logic [WIDE_BITS-1:0] div_dividend,
	output logic [WIDE_BITS-1:0] div_divisor,
	input  logic [WIDE_BITS-1:0] div_quotient,
	input  logic                 div_done
);

	localparam logic [WIDE_BITS-1:0] ROOT_MAX = {{(WIDE_BITS-ROOT_BITS){1'b0}}, {ROOT_BITS{1'b1}}};

	logic [VALUE_BITS-1:0] z_q;
	logic [WIDE_BITS-1:0]  x_q;
	logic [WIDE_BITS-1:0]  nx_q;
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  conv_q;
	logic                  out_valid_q;
	logic [ROOT_BITS-1:0]  root_q;
	logic [COUNT_BITS-1:0] used_q;
	logic                  conv_out_q;

	logic                  load;
	logic                  emit;
	logic                  out_free;
	logic [WIDE_BITS-1:0]  half;
	logic [WIDE_BITS:0]    sum;
	logic [WIDE_BITS-1:0]  avg;
	logic [WIDE_BITS-1:0]  diff;
	logic [COUNT_BITS-1:0] limit;
	logic                  tol_met;

	assign out_free = ~out_valid_q | result.ready;
	assign load     = (ctrl.op == OP_LOAD) & sample.valid;
	assign emit     = (ctrl.op == OP_EMIT) & out_free;

	assign half  = {{(WIDE_BITS-VALUE_BITS+1){1'b0}}, sample.radicand[VALUE_BITS-1:1]};
	assign sum   = {1'b0, x_q} + {1'b0, div_quotient};
	assign avg   = sum[WIDE_BITS:1];
	assign diff  = (nx_q > x_q) ? (nx_q - x_q) : (x_q - nx_q);
	assign limit = cfg.stop_mode ? cfg.max_iterations : cfg.fixed_iterations;
	// absolute change against tolerance, only in tolerance mode
	assign tol_met = cfg.stop_mode &
		(diff <= {{(WIDE_BITS-TOL_BITS){1'b0}}, cfg.tolerance});

	assign div_start    = (ctrl.op == OP_DIV_START);
	assign div_dividend = {z_q, {FRACTION_BITS{1'b0}}};
	assign div_divisor  = x_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				if (load) begin
					z_q   <= sample.radicand;
					cnt_q <= '0;
					// raw radicand of one would start at zero: use one instead
					if (half == '0 && sample.radicand != '0) begin
						x_q <= WIDE_BITS'(1);
					end else begin
						x_q <= half;
					end
					conv_q <= (sample.radicand == '0) | ~cfg.stop_mode;
				end
			end
			OP_AVG: begin
				nx_q <= (avg == '0) ? WIDE_BITS'(1) : avg;
			end
			OP_UPDATE: begin
				x_q   <= nx_q;
				cnt_q <= cnt_q + 1'b1;
				if (tol_met) begin
					conv_q <= 1'b1;
				end
			end
			OP_EMIT: begin
				if (emit) begin
					root_q     <= (x_q > ROOT_MAX) ? {ROOT_BITS{1'b1}} : x_q[ROOT_BITS-1:0];
					used_q     <= cnt_q;
					conv_out_q <= conv_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sample.ready           = (ctrl.op == OP_LOAD);
	assign result.valid           = out_valid_q;
	assign result.root            = root_q;
	assign result.iterations_used = used_q;
	assign result.converged       = conv_out_q;

	assign status.in_valid = sample.valid;
	assign status.z_zero   = (z_q == '0);
	assign status.cnt_done = (cnt_q == limit);
	assign status.div_done = div_done;
	assign status.tol_met  = tol_met;
	assign status.out_free = out_free;

endmodule

// ----- hw/rtl/heron_square_root.sv -----
// Heron square root of an unsigned Q16.16 radicand, result in Q16.16 (saturated to 25 bits).
// The estimate starts at half the radicand and is refined by x' = (x + z*2^16/x) / 2, either a
// fixed number of times or until the absolute change is within the tolerance (capped by the
// maximum count). A small microprogram sequences one shared 48-bit radix-2 divider: each
// update runs start, wait (48 divide steps), average, update and count check. When the
// tolerance ends it the count check is skipped, and a zero radicand goes straight to the
// output with no update. One item is worked at a time; the next is taken once the result
// is in the output register. Config registers are written through the cfg port; the user
// must write them only while the block is idle, which the block itself does not enforce.
module heron_square_root import hsr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	hsr_in_if.sink     sample,
	hsr_out_if.source  result,
	hsr_cfg_if.sink    cfg
);

	cfg_t                 cfg_q;
	ctrl_word_t           ctrl;
	status_t              status;
	logic                 div_start;
	logic [WIDE_BITS-1:0] div_dividend;
	logic [WIDE_BITS-1:0] div_divisor;
	logic [WIDE_BITS-1:0] div_quotient;
	logic                 div_done;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stop_mode        <= 1'b0;
			cfg_q.fixed_iterations <= COUNT_BITS'(10);
			cfg_q.tolerance        <= TOL_BITS'(1);
			cfg_q.max_iterations   <= COUNT_BITS'(32);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_STOP_MODE:        cfg_q.stop_mode        <= cfg.data[0];
				REG_FIXED_ITERATIONS: cfg_q.fixed_iterations <= cfg.data[COUNT_BITS-1:0];
				REG_TOLERANCE:        cfg_q.tolerance        <= cfg.data[TOL_BITS-1:0];
				REG_MAX_ITERATIONS:   cfg_q.max_iterations   <= cfg.data[COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	hsr_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	hsr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.ctrl         (ctrl),
		.status       (status),
		.sample       (sample),
		.result       (result),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_quotient (div_quotient),
		.div_done     (div_done)
	);

	hsr_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quotient),
		.done     (div_done)
	);

endmodule
